// File: design/robin_hood_hash_set_macros.svh
// Assertion helpers for the hash set
`ifndef ROBIN_HOOD_HASH_SET_MACROS_SVH
`define ROBIN_HOOD_HASH_SET_MACROS_SVH

// Check an implication on every clock edge outside reset
`define RH_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequence holds in the cycle after the antecedent
`define RH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/rhhs_pkg.sv
package rhhs_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 4096;
   localparam int unsigned KEY_W = 32;
   localparam int unsigned SIZE_W = 13;
   localparam int unsigned DISP_W = 12;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;
   localparam logic [KEY_W-1:0] EMPTY_KEY = 32'd0;
   localparam logic [DISP_W-1:0] DISP_MAX = 12'd4095;
   localparam logic [31:0] MIX_C1 = 32'hed5ad4bb;
   localparam logic [31:0] MIX_C2 = 32'hac4c1b51;
   localparam logic [31:0] MIX_C3 = 32'h31848bab;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        inserted;
      logic        full_error;
      logic [12:0] entry_count;
   } rsp_type;

endpackage

// File: design/robin_hood_hash_set.sv
// Channel | Direction | Handshake         | Payload
// req     | in        | valid / stall     | operation, address
// rsp     | out       | valid / stall     | hit, inserted, full_error, entry_count
// csr     | in        | valid / ready     | table_size
//
// One request at a time: hashing a key runs 3 mix rounds, one load and 32
// remainder steps, then each slot is read through S_RD and S_CHK. A lookup ends
// at a hit, an empty slot, the displacement bound or after probing every slot.
// An insert rehashes every occupied slot it passes and checks the final slot in S_FINAL.
// The response is registered after S_RESP; while it is stalled new requests stall.
// Reset starts a clearing pass over all TABLE_DEPTH slots with requests stalled.
`include "robin_hood_hash_set_macros.svh"

module robin_hood_hash_set
   import rhhs_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_data
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned PW = AW + 1;
   // modulo unit works on 32-bit dividend
   localparam int unsigned MODW = 5;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH, S_MOD, S_RD, S_CHK, S_RHASH, S_RMOD,
      S_DECIDE, S_FINAL, S_RESP
   } state_type;

   state_type state_ff;

   logic [31:0]     mem_q_ff;
   logic [AW-1:0]   raddr;
   logic            we;
   logic [AW-1:0]   waddr;
   logic [31:0]     wdata;

   logic [SIZE_W-1:0] size_ff;
   logic [PW-1:0]     n_ff;
   logic [SIZE_W-1:0] count_ff;
   logic [DISP_W-1:0] maxd_ff;
   logic [AW-1:0]     clr_ff;

   logic              op_ff;
   logic [31:0]       key_ff;
   logic [31:0]       cur_ff;
   logic [31:0]       res_ff;
   logic [PW-1:0]     home_ff;
   logic [PW-1:0]     pos_ff;
   logic [PW-1:0]     k_ff;
   logic              swapped_ff;
   logic              lookup_ff;
   logic [1:0]        hstep_ff;
   logic [31:0]       h_ff;
   logic [63:0]       rem_ff;
   logic [MODW-1:0]   mbit_ff;
   logic              brk_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   // table memory: 32-bit slots
   logic [31:0] slot_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         slot_mem[waddr] <= wdata;
      end
      mem_q_ff <= slot_mem[raddr];
   end

   // hash: xor-shift then multiply, one round per cycle
   function automatic logic [31:0] mix_round(input logic [31:0] x, input logic [1:0] r);
      logic [31:0] c;
      logic [31:0] y;
      begin
         c = (r == 2'd0) ? MIX_C1 : ((r == 2'd1) ? MIX_C2 : MIX_C3);
         y = (r == 2'd0) ? (x ^ (x >> 17)) : ((r == 2'd1) ? (x ^ (x >> 11)) : (x ^ (x >> 15)));
         return y * c;
      end
   endfunction

   logic [PW-1:0] pos_next;
   logic [PW-1:0] d_cur;
   logic [PW-1:0] d_res;
   logic [PW-1:0] rem_home;
   logic [DISP_W-1:0] d_sat;

   always_comb begin
      rem_home = rem_ff[32 +: PW];
      pos_next = ((pos_ff + PW'(1)) >= n_ff) ? '0 : pos_ff + PW'(1);
      d_cur = (pos_ff >= home_ff) ? pos_ff - home_ff : pos_ff + n_ff - home_ff;
      d_res = (pos_ff >= rem_home) ? pos_ff - rem_home
                                   : pos_ff + n_ff - rem_home;
      d_sat = (d_cur > PW'(DISP_MAX)) ? DISP_MAX : DISP_W'(d_cur);
   end

   assign raddr = AW'(pos_ff);
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   logic [32:0] mod_trial;
   assign mod_trial = {rem_ff[63:32], 1'b0} | 33'(rem_ff[31]) ;

   always_comb begin
      we = 1'b0;
      waddr = AW'(pos_ff);
      wdata = cur_ff;
      if (state_ff == S_CLEAR) begin
         we = 1'b1;
         waddr = clr_ff;
         wdata = EMPTY_KEY;
      end else if (state_ff == S_DECIDE && !brk_ff && res_ff != EMPTY_KEY
                   && d_res < d_cur) begin
         we = 1'b1;
      end else if (state_ff == S_FINAL && mem_q_ff == EMPTY_KEY && brk_ff) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         count_ff <= '0;
         maxd_ff <= '0;
         rsp_valid_ff <= 1'b0;
         size_ff <= SIZE_RESET;
      end else begin
         if (csr_valid) begin
            size_ff <= csr_data;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(TABLE_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  op_ff <= req_data.operation;
                  key_ff <= req_data.address;
                  cur_ff <= req_data.address;
                  n_ff <= (size_ff == '0) ? PW'(1) :
                          ((32'(size_ff) > TABLE_DEPTH) ? PW'(TABLE_DEPTH) : PW'(size_ff));
                  if (req_data.address == EMPTY_KEY) begin
                     rsp_ff <= '{hit: 1'b1, inserted: 1'b0, full_error: 1'b0,
                                 entry_count: count_ff};
                     state_ff <= S_RESP;
                  end else begin
                     h_ff <= req_data.address;
                     hstep_ff <= '0;
                     swapped_ff <= 1'b0;
                     brk_ff <= 1'b0;
                     state_ff <= S_HASH;
                  end
               end
            end
            S_HASH, S_RHASH: begin
               h_ff <= mix_round(h_ff, hstep_ff);
               hstep_ff <= hstep_ff + 2'd1;
               if (hstep_ff == 2'd2) begin
                  state_ff <= (state_ff == S_HASH) ? S_MOD : S_RMOD;
                  mbit_ff <= '0;
               end
            end
            S_MOD, S_RMOD: begin
               // restoring division remainder, one bit per cycle, start by loading
               if (mbit_ff == '0 && hstep_ff == 2'd3) begin
                  rem_ff <= {32'd0, h_ff ^ (h_ff >> 14)};
                  hstep_ff <= '0;
               end else begin
                  if (mod_trial >= 33'(n_ff)) begin
                     rem_ff <= {mod_trial[31:0] - 32'(n_ff), rem_ff[30:0], 1'b0};
                  end else begin
                     rem_ff <= {mod_trial[31:0], rem_ff[30:0], 1'b0};
                  end
                  mbit_ff <= mbit_ff + MODW'(1);
                  if (mbit_ff == MODW'(31)) begin
                     state_ff <= (state_ff == S_MOD) ? S_RD : S_DECIDE;
                     if (state_ff == S_MOD) begin
                        home_ff <= (mod_trial >= 33'(n_ff)) ? PW'(mod_trial - 33'(n_ff))
                                                             : PW'(mod_trial);
                        pos_ff <= (mod_trial >= 33'(n_ff)) ? PW'(mod_trial - 33'(n_ff))
                                                            : PW'(mod_trial);
                        k_ff <= '0;
                        lookup_ff <= (op_ff == OP_LOOKUP) ||
                                     (count_ff >= SIZE_W'(n_ff));
                     end
                  end
               end
            end
            S_RD: begin
               state_ff <= S_CHK;
            end
            S_CHK: begin
               res_ff <= mem_q_ff;
               if (lookup_ff) begin
                  if (mem_q_ff == key_ff) begin
                     rsp_ff <= '{1'b1, 1'b0, 1'b0, count_ff};
                     state_ff <= S_RESP;
                  end else if (mem_q_ff == EMPTY_KEY || k_ff + PW'(1) >= n_ff ||
                               32'(k_ff) >= 32'(maxd_ff)) begin
                     rsp_ff <= '{1'b0, 1'b0, (op_ff == OP_INSERT), count_ff};
                     state_ff <= S_RESP;
                  end else begin
                     k_ff <= k_ff + PW'(1);
                     pos_ff <= pos_next;
                     state_ff <= S_RD;
                  end
               end else if (mem_q_ff == EMPTY_KEY) begin
                  state_ff <= S_FINAL;
               end else if (!swapped_ff && mem_q_ff == key_ff) begin
                  rsp_ff <= '{1'b1, 1'b0, 1'b0, count_ff};
                  state_ff <= S_RESP;
               end else begin
                  h_ff <= mem_q_ff;
                  hstep_ff <= '0;
                  state_ff <= S_RHASH;
               end
            end
            S_DECIDE: begin
               if (d_res < d_cur) begin
                  if (d_sat > maxd_ff) begin
                     maxd_ff <= d_sat;
                  end
                  cur_ff <= res_ff;
                  swapped_ff <= 1'b1;
                  home_ff <= rem_home;
               end
               k_ff <= k_ff + PW'(1);
               pos_ff <= pos_next;
               if (k_ff + PW'(1) >= n_ff) begin
                  state_ff <= S_FINAL;
               end else begin
                  state_ff <= S_RD;
               end
            end
            S_FINAL: begin
               // on arrival only set brk_ff and decide in the next cycle, so the read is fresh
               if (!brk_ff) begin
                  brk_ff <= 1'b1;
               end else begin
                  if (mem_q_ff == EMPTY_KEY) begin
                     if (d_sat > maxd_ff) begin
                        maxd_ff <= d_sat;
                     end
                     count_ff <= count_ff + SIZE_W'(1);
                     rsp_ff <= '{1'b0, 1'b1, 1'b0, count_ff + SIZE_W'(1)};
                  end else begin
                     rsp_ff <= '{1'b0, 1'b0, 1'b0, count_ff};
                  end
                  brk_ff <= 1'b0;
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `RH_ASSERT_IMP(a_no_req_when_busy, state_ff != S_IDLE, req_stall, "request taken while busy")
   `RH_ASSERT_IMP(a_count_bound, 1'b1, 32'(count_ff) <= TABLE_DEPTH, "count exceeds depth")
   `RH_ASSERT_NEXT(a_resp_valid, state_ff == S_RESP, rsp_valid, "response not raised")

endmodule
